// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the E2E profile 6 check RTL.
// Every macro expects i_clk and i_rst_n in the scope of its use.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define E2E_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define E2E_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/e2e6_pkg.sv -----
// ---------------------------------------------------------------------------
// e2e6_pkg
// Types, codes and CRC helpers shared by the E2E profile 6 check modules.
// ---------------------------------------------------------------------------
package e2e6_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_ID           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA_COUNTER = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [12:0] MIN_LENGTH_RST = 13'd5;
    localparam logic [12:0] MAX_LENGTH_RST = 13'd4096;
    localparam logic [6:0]  MAX_DELTA_RST  = 7'd1;

    // Frame and protocol constants.
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [7:0]  COUNTER_INIT = 8'hFF;
    localparam int          HDR_LEN      = 5;

    // Detailed check status.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OK_LOST   = 3'd1,
        ST_ERROR     = 3'd2,
        ST_REPEATED  = 3'd3,
        ST_NO_NEW    = 3'd4,
        ST_WRONG_SEQ = 3'd5
    } t_status;

    // Mapped (state machine) status.
    typedef enum logic [2:0] {
        SM_OK        = 3'd0,
        SM_REPEATED  = 3'd1,
        SM_WRONG_SEQ = 3'd2,
        SM_NO_NEW    = 3'd3,
        SM_ERROR     = 3'd4
    } t_sm_status;

    // Return codes.
    localparam logic RET_OK      = 1'b0;
    localparam logic RET_BAD_LEN = 1'b1;

    // Per-frame fields after the current byte has been folded in.
    typedef struct packed {
        logic [15:0] crc;
        logic [15:0] rx_crc;
        logic [15:0] rx_length;
        logic [7:0]  rx_counter;
    } t_frame_fields;

    // Configuration seen by the end-of-frame check.
    typedef struct packed {
        logic [11:0] header_offset;
        logic [12:0] min_length;
        logic [12:0] max_length;
        logic [6:0]  max_delta;
        logic [15:0] id_crc;
    } t_chk_cfg;

    // One result transaction.
    typedef struct packed {
        logic        ret_code;
        t_status     status;
        t_sm_status  sm_status;
        logic [7:0]  rcv_counter;
    } t_result;

    // One byte of CRC-16 CCITT-FALSE, MSB first.
    function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Column table: effect of each state bit after sixteen zero bits.
    function automatic logic [255:0] zero16_cols();
        logic [255:0] t;
        logic [15:0]  c;
        t = '0;
        for (int i = 0; i < 16; i++) begin
            c = crc16_byte(crc16_byte(16'h0001 << i, 8'h00), 8'h00);
            t[i*16 +: 16] = c;
        end
        return t;
    endfunction

    // Column table: effect of each data ID bit fed from a zero state.
    function automatic logic [255:0] id_cols();
        logic [255:0] t;
        logic [15:0]  d;
        t = '0;
        for (int i = 0; i < 16; i++) begin
            d = 16'h0001 << i;
            t[i*16 +: 16] = crc16_byte(crc16_byte(16'h0000, d[15:8]), d[7:0]);
        end
        return t;
    endfunction

    localparam logic [255:0] ZERO16_COLS = zero16_cols();
    localparam logic [255:0] ID_COLS     = id_cols();

    // CRC state advanced over sixteen zero bits, as one XOR matrix.
    function automatic logic [15:0] crc16_zero16(logic [15:0] c);
        logic [15:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (c[i]) begin
                r = r ^ ZERO16_COLS[i*16 +: 16];
            end
        end
        return r;
    endfunction

    // Contribution of the data ID bytes to the CRC, from a zero state.
    function automatic logic [15:0] crc16_id(logic [15:0] d);
        logic [15:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (d[i]) begin
                r = r ^ ID_COLS[i*16 +: 16];
            end
        end
        return r;
    endfunction

    // Detailed status to mapped status.
    function automatic t_sm_status map_status(t_status st);
        t_sm_status m;
        unique case (st) inside
            ST_OK, ST_OK_LOST: m = SM_OK;
            ST_REPEATED:       m = SM_REPEATED;
            ST_NO_NEW:         m = SM_NO_NEW;
            ST_WRONG_SEQ:      m = SM_WRONG_SEQ;
            default:           m = SM_ERROR;
        endcase
        return m;
    endfunction

endpackage

// ----- hw/rtl/e2e6_frame.sv -----
// ---------------------------------------------------------------------------
// e2e6_frame
// Per-frame byte datapath: byte position, running CRC and header capture.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module e2e6_frame #(
    parameter int  MAX_BYTES = 4096,
    localparam int POS_W     = $clog2(MAX_BYTES + 1),
    localparam int LEN_W     = $clog2(MAX_BYTES + 2)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last,
    input  logic                   i_no_data,
    input  logic [11:0]            i_header_offset,
    output e2e6_pkg::t_frame_fields o_fields,
    output logic [LEN_W-1:0]       o_len
);

    localparam int HW = (POS_W > 13) ? POS_W : 13;

    logic [POS_W-1:0] r_pos;
    logic [15:0]      r_crc;
    logic [15:0]      r_rx_crc;
    logic [15:0]      r_rx_length;
    logic [7:0]       r_rx_counter;

    logic [HW-1:0]    pos_x;
    logic [HW-1:0]    hdr_x;
    logic             in_range;
    e2e6_pkg::t_frame_fields n_fields;

    // Position compares against the header window.
    assign pos_x    = HW'(r_pos);
    assign hdr_x    = HW'(i_header_offset);
    assign in_range = r_pos < POS_W'(MAX_BYTES);

    // Fold the current byte into the CRC (all but the two CRC bytes) and capture the header fields.
    always_comb begin
        n_fields.crc        = r_crc;
        n_fields.rx_crc     = r_rx_crc;
        n_fields.rx_length  = r_rx_length;
        n_fields.rx_counter = r_rx_counter;
        if (in_range) begin
            if (pos_x == hdr_x) begin
                n_fields.rx_crc[15:8] = i_data_byte;
            end else if (pos_x == hdr_x + HW'(1)) begin
                n_fields.rx_crc[7:0] = i_data_byte;
            end else begin
                n_fields.crc = e2e6_pkg::crc16_byte(r_crc, i_data_byte);
            end
            if (pos_x == hdr_x + HW'(2)) begin
                n_fields.rx_length[15:8] = i_data_byte;
            end else if (pos_x == hdr_x + HW'(3)) begin
                n_fields.rx_length[7:0] = i_data_byte;
            end else if (pos_x == hdr_x + HW'(4)) begin
                n_fields.rx_counter = i_data_byte;
            end
        end
    end

    assign o_fields = n_fields;
    assign o_len    = LEN_W'(r_pos) + LEN_W'(1);

    // Frame state: cleared at the end of every frame, held on no-data items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_crc        <= e2e6_pkg::CRC_INIT;
            r_rx_crc     <= '0;
            r_rx_length  <= '0;
            r_rx_counter <= '0;
        end else if (i_advance && !i_no_data) begin
            if (i_last) begin
                r_pos        <= '0;
                r_crc        <= e2e6_pkg::CRC_INIT;
                r_rx_crc     <= '0;
                r_rx_length  <= '0;
                r_rx_counter <= '0;
            end else begin
                r_crc        <= n_fields.crc;
                r_rx_crc     <= n_fields.rx_crc;
                r_rx_length  <= n_fields.rx_length;
                r_rx_counter <= n_fields.rx_counter;
                if (in_range) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    // The frame end always returns the datapath to its start state.
    `E2E_ASSERT_NXT(a_frame_cleared, i_advance && !i_no_data && i_last,
        r_pos == '0 && r_crc == e2e6_pkg::CRC_INIT, "frame state not cleared at frame end")

endmodule

// ----- hw/rtl/e2e6_check.sv -----
// ---------------------------------------------------------------------------
// e2e6_check
// End-of-frame evaluation: length bounds, CRC and length field, counter
// delta, and the stored counter and status.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module e2e6_check #(
    parameter int  MAX_BYTES = 4096,
    localparam int LEN_W     = $clog2(MAX_BYTES + 2)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  logic                    i_no_data,
    input  logic                    i_last,
    input  logic [LEN_W-1:0]        i_len,
    input  e2e6_pkg::t_frame_fields i_fields,
    input  e2e6_pkg::t_chk_cfg      i_cfg,
    output e2e6_pkg::t_result       o_result
);

    localparam int CW = (LEN_W > 16) ? LEN_W : 16;

    logic [7:0]          r_last_counter;
    e2e6_pkg::t_status   r_check_status;

    logic [CW-1:0]       len_x;
    logic                len_bad;
    logic [15:0]         crc_fin;
    logic                match;
    logic [7:0]          delta;
    e2e6_pkg::t_status   st;

    // Length bounds of the finished frame.
    assign len_x   = CW'(i_len);
    assign len_bad = (len_x < CW'(i_cfg.min_length)) ||
                     (len_x > CW'(i_cfg.max_length)) ||
                     (len_x < CW'(i_cfg.header_offset) + CW'(e2e6_pkg::HDR_LEN)) ||
                     (len_x > CW'(MAX_BYTES));

    // Final CRC: data CRC carried over the data ID bytes.
    assign crc_fin = e2e6_pkg::crc16_zero16(i_fields.crc) ^ i_cfg.id_crc;
    assign match   = (i_fields.rx_crc == crc_fin) && (CW'(i_fields.rx_length) == len_x);
    assign delta   = i_fields.rx_counter - r_last_counter;

    // Status of a frame with the right length.
    always_comb begin
        if (!match) begin
            st = e2e6_pkg::ST_ERROR;
        end else if (delta > {1'b0, i_cfg.max_delta}) begin
            st = e2e6_pkg::ST_WRONG_SEQ;
        end else if (delta == 8'd0) begin
            st = e2e6_pkg::ST_REPEATED;
        end else if (delta == 8'd1) begin
            st = e2e6_pkg::ST_OK;
        end else begin
            st = e2e6_pkg::ST_OK_LOST;
        end
    end

    // Result transaction for a no-data item or a frame end.
    always_comb begin
        if (i_no_data) begin
            o_result.ret_code    = e2e6_pkg::RET_OK;
            o_result.status      = e2e6_pkg::ST_NO_NEW;
            o_result.sm_status   = e2e6_pkg::SM_NO_NEW;
            o_result.rcv_counter = '0;
        end else if (len_bad) begin
            o_result.ret_code    = e2e6_pkg::RET_BAD_LEN;
            o_result.status      = r_check_status;
            o_result.sm_status   = e2e6_pkg::SM_ERROR;
            o_result.rcv_counter = '0;
        end else begin
            o_result.ret_code    = e2e6_pkg::RET_OK;
            o_result.status      = st;
            o_result.sm_status   = e2e6_pkg::map_status(st);
            o_result.rcv_counter = i_fields.rx_counter;
        end
    end

    // Stored counter and status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_counter <= e2e6_pkg::COUNTER_INIT;
            r_check_status <= e2e6_pkg::ST_ERROR;
        end else if (i_advance) begin
            if (i_no_data) begin
                r_check_status <= e2e6_pkg::ST_NO_NEW;
            end else if (i_last && !len_bad) begin
                r_check_status <= st;
                if (match) begin
                    r_last_counter <= i_fields.rx_counter;
                end
            end
        end
    end

    // A rejected length leaves the stored counter and status alone.
    `E2E_ASSERT_NXT(a_bad_len_keeps_state, i_advance && !i_no_data && i_last && len_bad,
        $stable(r_last_counter) && $stable(r_check_status), "bad length changed state")

    // A mismatched frame never moves the stored counter.
    `E2E_ASSERT_NXT(a_mismatch_keeps_counter, i_advance && !i_no_data && !match,
        $stable(r_last_counter), "counter stored from mismatched frame")

endmodule

// ----- hw/rtl/e2e_profile6_check.sv -----
// ---------------------------------------------------------------------------
// e2e_profile6_check
// Receiver-side E2E profile 6 check over a byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   Message bytes enter on the input channel (i_in_valid / o_in_stall), one
//   byte per transaction, with i_last on the final byte. A transaction with
//   i_no_data high stands for a check call without new data. Each frame end
//   and each no-data transaction gives one result transaction on the output
//   channel (o_out_valid / i_out_stall); other bytes give none.
//   Path: a taken transaction goes to the input register, and its result
//   then to the result register; the bytewise CRC update and the
//   end-of-frame compares sit between the two. Throughput: one transaction
//   per cycle while no result-bearing transaction waits on a stall.
//   When the receiver stalls, the result register holds; bytes that give no
//   result still flow, and only a result-bearing transaction waits, which
//   then backs up the input channel.
//   Configuration: i_cfg_we writes register i_cfg_index (0 data ID, 1 header
//   offset, 2 min length, 3 max length, 4 max counter delta) with i_cfg_data.
//   Write only while no transaction is in flight; the block does not check.
//   Reset (synchronous, active low) empties both registers, restarts the
//   frame, and loads the register defaults, last counter 0xFF and status
//   error. After reset the input register is empty, so input is not stalled.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module e2e_profile6_check #(
    parameter int MAX_BYTES = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [e2e6_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [e2e6_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_last,
    input  logic                            i_no_data,
    // Output channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_ret_code,
    output logic [2:0]                      o_status,
    output logic [2:0]                      o_sm_status,
    output logic [7:0]                      o_received_counter
);

    localparam int LEN_W = $clog2(MAX_BYTES + 2);

    // Configuration registers; the data ID is kept as its CRC contribution.
    logic [15:0] r_id_crc;
    logic [11:0] r_header_offset;
    logic [12:0] r_min_length;
    logic [12:0] r_max_length;
    logic [6:0]  r_max_delta;

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_in_no_data;

    // Result register.
    logic                    r_out_valid;
    e2e6_pkg::t_result       r_out;

    logic                    need_out;
    logic                    advance;
    logic                    in_accept;
    logic [LEN_W-1:0]        frame_len;
    e2e6_pkg::t_frame_fields frame_fields;
    e2e6_pkg::t_chk_cfg      chk_cfg;
    e2e6_pkg::t_result       n_result;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_crc        <= e2e6_pkg::crc16_id(16'h0000);
            r_header_offset <= '0;
            r_min_length    <= e2e6_pkg::MIN_LENGTH_RST;
            r_max_length    <= e2e6_pkg::MAX_LENGTH_RST;
            r_max_delta     <= e2e6_pkg::MAX_DELTA_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                e2e6_pkg::CFG_DATA_ID:           r_id_crc <= e2e6_pkg::crc16_id(i_cfg_data);
                e2e6_pkg::CFG_HEADER_OFFSET:     r_header_offset <= i_cfg_data[11:0];
                e2e6_pkg::CFG_MIN_LENGTH:        r_min_length <= i_cfg_data[12:0];
                e2e6_pkg::CFG_MAX_LENGTH:        r_max_length <= i_cfg_data[12:0];
                e2e6_pkg::CFG_MAX_DELTA_COUNTER: r_max_delta <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    assign chk_cfg.header_offset = r_header_offset;
    assign chk_cfg.min_length    = r_min_length;
    assign chk_cfg.max_length    = r_max_length;
    assign chk_cfg.max_delta     = r_max_delta;
    assign chk_cfg.id_crc        = r_id_crc;

    // Flow control: only a result-bearing transaction waits on the output.
    assign need_out   = r_in_valid && (r_in_last || r_in_no_data);
    assign advance    = r_in_valid && (!need_out || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte    <= i_data_byte;
            r_in_last    <= i_last;
            r_in_no_data <= i_no_data;
        end
    end

    e2e6_frame #(
        .MAX_BYTES (MAX_BYTES)
    ) u_frame (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_data_byte     (r_in_byte),
        .i_last          (r_in_last),
        .i_no_data       (r_in_no_data),
        .i_header_offset (r_header_offset),
        .o_fields        (frame_fields),
        .o_len           (frame_len)
    );

    e2e6_check #(
        .MAX_BYTES (MAX_BYTES)
    ) u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_no_data (r_in_no_data),
        .i_last    (r_in_last),
        .i_len     (frame_len),
        .i_fields  (frame_fields),
        .i_cfg     (chk_cfg),
        .o_result  (n_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && need_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && need_out) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_ret_code         = r_out.ret_code;
    assign o_status           = r_out.status;
    assign o_sm_status        = r_out.sm_status;
    assign o_received_counter = r_out.rcv_counter;

    // The input side stalls only behind a held result.
    `E2E_ASSERT_IMP(a_stall_cause, o_in_stall,
        need_out && r_out_valid && i_out_stall, "input stalled without a held result")

    // A result-bearing transaction that moves on is always presented.
    `E2E_ASSERT_NXT(a_result_loaded, advance && need_out,
        r_out_valid, "result transaction lost")

endmodule
